// ----- rtl/macd_ema_filter_bank_macros.svh -----
// Assertion macros shared by the filter bank RTL.
// Each macro names the assertion, the clock, the active-low reset and the property.
`ifndef MACD_EMA_FILTER_BANK_MACROS_SVH
`define MACD_EMA_FILTER_BANK_MACROS_SVH
`ifndef SYNTHESIS
`define MEF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("property violated");
`define MEF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define MEF_ASSERT(lbl, clk, rst_n, prop)
`define MEF_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/mef_pkg.sv -----
`default_nettype none

package mef_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned GUARD_BITS = 16;
  localparam int unsigned AVG_W      = DATA_W + GUARD_BITS;
  localparam int unsigned PERIOD_W   = 10;
  // (period + 1) * 2 for the largest period
  localparam int unsigned DIVISOR_W  = PERIOD_W + 2;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_FAST   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOW   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIGNAL = 2'd2;

  localparam int unsigned FAST_PERIOD_RST   = 12;
  localparam int unsigned SLOW_PERIOD_RST   = 26;
  localparam int unsigned SIGNAL_PERIOD_RST = 9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_FAST,
    ST_SLOW,
    ST_MACD,
    ST_SIG_ISSUE,
    ST_SIGNAL,
    ST_SIG_OUT,
    ST_HIST,
    ST_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    EMA_IDLE,
    EMA_ABS,
    EMA_MLO,
    EMA_MHI,
    EMA_SUM,
    EMA_APPLY
  } ema_step_e;

endpackage

`default_nettype wire

// ----- rtl/macd_ema_filter_bank.sv -----
// MACD filter bank. Each transfer on the input channel carries one Q16.16 price sample and a
// series-start flag; each transfer on the output channel carries macd (fast minus slow
// average), the signal average of macd and the histogram (macd minus signal), all Q16.16
// saturated to 32 bits, plus a period error flag. The three averages are kept in Q16.32 and
// are updated one after another on a single shared multiplier: each update runs through
// subtract, magnitude, low product, high product, round and clip, and apply. A sample that
// starts a series, or one taken while the periods are invalid (fast not below slow, or any
// period zero), leaves or seeds the state without using the multiplier; invalid periods give
// zeros with period_error set. The periods sit in three APB registers at byte addresses 0
// (fast), 4 (slow) and 8 (signal), 10 bits each; a write starts an alpha recompute on a
// bit-serial divider, one period at a time, and in_ready_o stays low until every pending
// alpha is done. The output register lets the next sample be taken while a result still
// waits for out_ready_i.
`default_nettype none

`include "macd_ema_filter_bank_macros.svh"

module macd_ema_filter_bank
  import mef_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_W-1:0]     price_i,
  input  logic                         series_start_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_W-1:0]     macd_value_o,
  output logic signed [DATA_W-1:0]     signal_value_o,
  output logic signed [DATA_W-1:0]     histogram_o,
  output logic                         period_error_o,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  output logic [APB_DATA_W-1:0]        prdata,
  output logic                         pready
);

  localparam int unsigned ALPHA_W = FRACTION_BITS + 1;
  localparam int unsigned ONE     = 1 << FRACTION_BITS;
  localparam int unsigned RND_W   = AVG_W + 2;
  localparam int unsigned SAT_W   = RND_W - GUARD_BITS;

  // Reset alphas, round-half-up of 2 * one / (period + 1).
  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST =
    ALPHA_W'(((4 * ONE) + (FAST_PERIOD_RST + 1)) / (2 * (FAST_PERIOD_RST + 1)));
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST =
    ALPHA_W'(((4 * ONE) + (SLOW_PERIOD_RST + 1)) / (2 * (SLOW_PERIOD_RST + 1)));
  localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST =
    ALPHA_W'(((4 * ONE) + (SIGNAL_PERIOD_RST + 1)) / (2 * (SIGNAL_PERIOD_RST + 1)));
  localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (GUARD_BITS - 1);

  // Round Q16.32 to Q16.16: add half, floor shift.
  function automatic logic [SAT_W-1:0] round_guard(input logic [RND_W-1:0] v);
    logic [RND_W-1:0] s;
    s = v + RND_HALF;
    return s[RND_W-1:GUARD_BITS];
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic [DATA_W-1:0] sat_data(input logic [SAT_W-1:0] v);
    logic fits;
    fits = (v[SAT_W-1:DATA_W-1] == '0) || (v[SAT_W-1:DATA_W-1] == '1);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W - 1){1'b1}}};
    end
  endfunction

  // Configuration registers
  logic [PERIOD_W-1:0]  fast_period_q, slow_period_q, signal_period_q;
  logic [ALPHA_W-1:0]   fast_alpha_q, slow_alpha_q, signal_alpha_q;
  logic [2:0]           pend_q, pend_d, pend_set, pend_clr;
  logic [REG_IDX_W-1:0] div_sel_q, div_sel_d;

  // Filter state
  logic [AVG_W-1:0]     fast_avg_q, fast_avg_d;
  logic [AVG_W-1:0]     slow_avg_q, slow_avg_d;
  logic [AVG_W-1:0]     signal_avg_q, signal_avg_d;
  top_state_e           state_q, state_d;

  // Per-sample working values
  logic [DATA_W-1:0]    price_q;
  logic [DATA_W-1:0]    macd_q, macd_d;
  logic [DATA_W-1:0]    sig_q, sig_d;
  logic [DATA_W-1:0]    hist_q, hist_d;
  logic                 err_q, err_d;

  // Output register
  logic                 out_valid_q, out_valid_d;
  logic [DATA_W-1:0]    out_macd_q, out_sig_q, out_hist_q;
  logic                 out_err_q;
  logic                 out_load;

  // Shared units
  logic                 ema_start, ema_done;
  logic [AVG_W-1:0]     ema_avg_in, ema_x_in, ema_avg_out;
  logic [ALPHA_W-1:0]   ema_alpha_in;
  logic                 div_start, div_done;
  logic [PERIOD_W-1:0]  div_period;
  logic [ALPHA_W-1:0]   div_alpha;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic                 in_accept;
  logic                 period_bad;
  logic [AVG_W-1:0]     price_in_x;
  logic [RND_W-1:0]     macd_diff;
  logic [SAT_W-1:0]     hist_diff;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_FAST:   prdata = APB_DATA_W'(fast_period_q);
      REG_SLOW:   prdata = APB_DATA_W'(slow_period_q);
      REG_SIGNAL: prdata = APB_DATA_W'(signal_period_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    pend_set = '0;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FAST:   pend_set = 3'b001;
        REG_SLOW:   pend_set = 3'b010;
        REG_SIGNAL: pend_set = 3'b100;
        default:    pend_set = '0;
      endcase
    end
  end

  // A write that lands while its alpha is being worked out marks it pending again.
  assign pend_d = (pend_q & ~pend_clr) | pend_set;

  assign in_ready_o = (state_q == ST_IDLE) && (pend_q == '0);
  assign in_accept  = in_valid_i && in_ready_o;
  assign period_bad = (fast_period_q >= slow_period_q) || (fast_period_q == '0) ||
                      (slow_period_q == '0) || (signal_period_q == '0);
  assign price_in_x = {price_i, {GUARD_BITS{1'b0}}};
  assign macd_diff  = {{2{fast_avg_q[AVG_W-1]}}, fast_avg_q} -
                      {{2{slow_avg_q[AVG_W-1]}}, slow_avg_q};
  assign hist_diff  = {{2{macd_q[DATA_W-1]}}, macd_q} - {{2{sig_q[DATA_W-1]}}, sig_q};

  // Sequencer: alpha recompute, then fast, slow and signal updates on the shared unit.
  always_comb begin
    state_d      = state_q;
    fast_avg_d   = fast_avg_q;
    slow_avg_d   = slow_avg_q;
    signal_avg_d = signal_avg_q;
    macd_d       = macd_q;
    sig_d        = sig_q;
    hist_d       = hist_q;
    err_d        = err_q;
    ema_start    = 1'b0;
    ema_avg_in   = fast_avg_q;
    ema_x_in     = {price_q, {GUARD_BITS{1'b0}}};
    ema_alpha_in = fast_alpha_q;
    div_start    = 1'b0;
    div_sel_d    = div_sel_q;
    div_period   = fast_period_q;
    pend_clr     = '0;
    out_load     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (pend_q != '0) begin
          div_start = 1'b1;
          state_d   = ST_ALPHA;
          if (pend_q[0]) begin
            div_sel_d  = REG_FAST;
            div_period = fast_period_q;
            pend_clr   = 3'b001;
          end else if (pend_q[1]) begin
            div_sel_d  = REG_SLOW;
            div_period = slow_period_q;
            pend_clr   = 3'b010;
          end else begin
            div_sel_d  = REG_SIGNAL;
            div_period = signal_period_q;
            pend_clr   = 3'b100;
          end
        end else if (in_valid_i) begin
          if (period_bad) begin
            // Invalid periods: zeros with the error flag, state untouched.
            macd_d  = '0;
            sig_d   = '0;
            hist_d  = '0;
            err_d   = 1'b1;
            state_d = ST_DONE;
          end else if (series_start_i) begin
            // Seed fast and slow with the price, signal with their difference.
            fast_avg_d   = price_in_x;
            slow_avg_d   = price_in_x;
            signal_avg_d = '0;
            macd_d       = '0;
            sig_d        = '0;
            hist_d       = '0;
            err_d        = 1'b0;
            state_d      = ST_DONE;
          end else begin
            ema_start = 1'b1;
            ema_x_in  = price_in_x;
            err_d     = 1'b0;
            state_d   = ST_FAST;
          end
        end
      end
      ST_ALPHA: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_FAST: begin
        if (ema_done) begin
          fast_avg_d   = ema_avg_out;
          ema_start    = 1'b1;
          ema_avg_in   = slow_avg_q;
          ema_alpha_in = slow_alpha_q;
          state_d      = ST_SLOW;
        end
      end
      ST_SLOW: begin
        if (ema_done) begin
          slow_avg_d = ema_avg_out;
          state_d    = ST_MACD;
        end
      end
      ST_MACD: begin
        macd_d  = sat_data(round_guard(macd_diff));
        state_d = ST_SIG_ISSUE;
      end
      ST_SIG_ISSUE: begin
        ema_start    = 1'b1;
        ema_avg_in   = signal_avg_q;
        ema_x_in     = {macd_q, {GUARD_BITS{1'b0}}};
        ema_alpha_in = signal_alpha_q;
        state_d      = ST_SIGNAL;
      end
      ST_SIGNAL: begin
        if (ema_done) begin
          signal_avg_d = ema_avg_out;
          state_d      = ST_SIG_OUT;
        end
      end
      ST_SIG_OUT: begin
        sig_d   = sat_data(round_guard({{2{signal_avg_q[AVG_W-1]}}, signal_avg_q}));
        state_d = ST_HIST;
      end
      ST_HIST: begin
        hist_d  = sat_data(hist_diff);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      fast_avg_q      <= '0;
      slow_avg_q      <= '0;
      signal_avg_q    <= '0;
      fast_period_q   <= PERIOD_W'(FAST_PERIOD_RST);
      slow_period_q   <= PERIOD_W'(SLOW_PERIOD_RST);
      signal_period_q <= PERIOD_W'(SIGNAL_PERIOD_RST);
      fast_alpha_q    <= FAST_ALPHA_RST;
      slow_alpha_q    <= SLOW_ALPHA_RST;
      signal_alpha_q  <= SIGNAL_ALPHA_RST;
      pend_q          <= '0;
      div_sel_q       <= REG_FAST;
      out_valid_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      fast_avg_q   <= fast_avg_d;
      slow_avg_q   <= slow_avg_d;
      signal_avg_q <= signal_avg_d;
      pend_q       <= pend_d;
      div_sel_q    <= div_sel_d;
      out_valid_q  <= out_valid_d;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_FAST:   fast_period_q   <= pwdata[PERIOD_W-1:0];
          REG_SLOW:   slow_period_q   <= pwdata[PERIOD_W-1:0];
          REG_SIGNAL: signal_period_q <= pwdata[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
      if (div_done) begin
        unique case (div_sel_q)
          REG_FAST:   fast_alpha_q   <= div_alpha;
          REG_SLOW:   slow_alpha_q   <= div_alpha;
          REG_SIGNAL: signal_alpha_q <= div_alpha;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      price_q <= price_i;
    end
    macd_q <= macd_d;
    sig_q  <= sig_d;
    hist_q <= hist_d;
    err_q  <= err_d;
    if (out_load) begin
      out_macd_q <= macd_q;
      out_sig_q  <= sig_q;
      out_hist_q <= hist_q;
      out_err_q  <= err_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign macd_value_o   = out_macd_q;
  assign signal_value_o = out_sig_q;
  assign histogram_o    = out_hist_q;
  assign period_error_o = out_err_q;

  mef_ema_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ema (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ema_start),
    .avg_i   (ema_avg_in),
    .x_i     (ema_x_in),
    .alpha_i (ema_alpha_in),
    .done_o  (ema_done),
    .avg_o   (ema_avg_out)
  );

  mef_alpha_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alpha_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .period_i (div_period),
    .done_o   (div_done),
    .alpha_o  (div_alpha)
  );

  `MEF_ASSERT(a_err_keeps_state, clk_i, rst_ni, (in_accept && period_bad) |=> $stable(fast_avg_q) && $stable(slow_avg_q) && $stable(signal_avg_q))
  `MEF_ASSERT(a_load_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `MEF_ASSERT(a_err_gives_zero, clk_i, rst_ni, (out_valid_q && out_err_q) |-> (out_macd_q == '0 && out_sig_q == '0 && out_hist_q == '0))
  `MEF_ASSERT(a_ema_done_state, clk_i, rst_ni, ema_done |-> (state_q == ST_FAST || state_q == ST_SLOW || state_q == ST_SIGNAL))
  `MEF_ASSERT_NEVER(a_div_outside_alpha, clk_i, rst_ni, div_done && (state_q != ST_ALPHA))

endmodule

`default_nettype wire

// ----- rtl/mef_alpha_div.sv -----
`default_nettype none

`include "macd_ema_filter_bank_macros.svh"

// Restoring divider for alpha = round(2 * 2^F / (period + 1)), one quotient bit a cycle.
module mef_alpha_div
  import mef_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [PERIOD_W-1:0]      period_i,
  output logic                     done_o,
  output logic [FRACTION_BITS:0]   alpha_o
);

  localparam int unsigned ALPHA_W = FRACTION_BITS + 1;
  localparam int unsigned NUM_W   = FRACTION_BITS + 3;
  localparam int unsigned CNT_W   = $clog2(NUM_W);
  localparam int unsigned REM_W   = DIVISOR_W;
  localparam logic [NUM_W-1:0] ONE = NUM_W'(1) << FRACTION_BITS;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [NUM_W-1:0]    quo_q;
  logic [REM_W-1:0]    rem_q;
  logic [DIVISOR_W-1:0] divisor_q;

  logic [PERIOD_W:0]   den;
  logic [NUM_W-1:0]    num;
  logic [REM_W:0]      shift;
  logic [REM_W:0]      trial;
  logic                ge;
  logic [REM_W-1:0]    rem_next;

  // Numerator 4*one + den and divisor 2*den give round-half-up of 2*one/den.
  assign den      = {1'b0, period_i} + (PERIOD_W + 1)'(1);
  assign num      = (NUM_W'(1) << (FRACTION_BITS + 2)) + NUM_W'(den);
  assign shift    = {rem_q, quo_q[NUM_W-1]};
  assign trial    = shift - {1'b0, divisor_q};
  assign ge       = shift >= {1'b0, divisor_q};
  assign rem_next = ge ? trial[REM_W-1:0] : shift[REM_W-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= num;
      rem_q     <= '0;
      divisor_q <= {den, 1'b0};
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_next;
    end
  end

  // Clip to 1.0 for period zero.
  assign alpha_o = (quo_q > ONE) ? ONE[ALPHA_W-1:0] : quo_q[ALPHA_W-1:0];
  assign done_o  = done_q;

  `MEF_ASSERT(a_no_restart, clk_i, rst_ni, start_i |-> !busy_q)
  `MEF_ASSERT(a_done_ends_run, clk_i, rst_ni, done_q |-> $past(busy_q) && !busy_q)
  `MEF_ASSERT(a_rem_below_divisor, clk_i, rst_ni, busy_q |-> (rem_q < divisor_q))

endmodule

`default_nettype wire

// ----- rtl/mef_ema_unit.sv -----
`default_nettype none

// One exponential average step: avg += sign(d) * round(|d| * alpha / 2^F), d = x - avg.
// The single multiplier is used twice, once for the low and once for the high part of |d|.
module mef_ema_unit
  import mef_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [AVG_W-1:0]       avg_i,
  input  logic [AVG_W-1:0]       x_i,
  input  logic [FRACTION_BITS:0] alpha_i,
  output logic                   done_o,
  output logic [AVG_W-1:0]       avg_o
);

  localparam int unsigned ALPHA_W = FRACTION_BITS + 1;
  localparam int unsigned DIFF_W  = AVG_W + 1;
  localparam int unsigned MAG_W   = AVG_W;
  localparam int unsigned HI_W    = MAG_W - FRACTION_BITS;
  localparam int unsigned PROD_W  = HI_W + ALPHA_W;
  localparam int unsigned LP_W    = PROD_W - FRACTION_BITS;
  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRACTION_BITS - 1);

  ema_step_e            step_q, step_d;
  logic [AVG_W-1:0]     avg_q;
  logic [ALPHA_W-1:0]   alpha_q;
  logic [DIFF_W-1:0]    diff_q;
  logic                 neg_q;
  logic [MAG_W-1:0]     mag_q;
  logic [PROD_W-1:0]    prod_q;
  logic [LP_W-1:0]      lp_q;
  logic [MAG_W-1:0]     q_q;

  logic [DIFF_W-1:0]    diff_new;
  logic [DIFF_W-1:0]    diff_neg;
  logic [HI_W-1:0]      mul_a;
  logic [PROD_W-1:0]    product;
  logic [PROD_W-1:0]    lp_sum;
  logic [PROD_W-1:0]    q_sum;
  logic [MAG_W-1:0]     q_clip;

  assign diff_new = {x_i[AVG_W-1], x_i} - {avg_i[AVG_W-1], avg_i};
  assign diff_neg = DIFF_W'(0) - diff_q;

  // Low FRACTION_BITS bits first, then the upper bits of |d|.
  assign mul_a   = (step_q == EMA_MLO) ? HI_W'(mag_q[FRACTION_BITS-1:0])
                                       : mag_q[MAG_W-1:FRACTION_BITS];
  assign product = PROD_W'(mul_a) * PROD_W'(alpha_q);
  assign lp_sum  = prod_q + HALF;
  assign q_sum   = prod_q + PROD_W'(lp_q);
  assign q_clip  = (q_sum > PROD_W'(mag_q)) ? mag_q : q_sum[MAG_W-1:0];

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      EMA_IDLE:  if (start_i) step_d = EMA_ABS;
      EMA_ABS:   step_d = EMA_MLO;
      EMA_MLO:   step_d = EMA_MHI;
      EMA_MHI:   step_d = EMA_SUM;
      EMA_SUM:   step_d = EMA_APPLY;
      EMA_APPLY: step_d = start_i ? EMA_ABS : EMA_IDLE;
      default:   step_d = EMA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= EMA_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      avg_q   <= avg_i;
      alpha_q <= alpha_i;
      diff_q  <= diff_new;
    end
    unique case (step_q)
      EMA_ABS: begin
        neg_q <= diff_q[DIFF_W-1];
        mag_q <= diff_q[DIFF_W-1] ? diff_neg[MAG_W-1:0] : diff_q[MAG_W-1:0];
      end
      EMA_MLO: begin
        prod_q <= product;
      end
      EMA_MHI: begin
        lp_q   <= lp_sum[PROD_W-1:FRACTION_BITS];
        prod_q <= product;
      end
      EMA_SUM: begin
        q_q <= q_clip;
      end
      default: begin
      end
    endcase
  end

  assign done_o = (step_q == EMA_APPLY);
  assign avg_o  = neg_q ? (avg_q - q_q) : (avg_q + q_q);

endmodule

`default_nettype wire

// ----- tb/macd_ema_filter_bank_test.sv -----
module macd_ema_filter_bank_test
  import mef_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRACTION_BITS   = 16;
  localparam int unsigned MAX_IDLE        = 10;
  localparam int unsigned ITEM_TARGET     = 550;
  // Long enough for the block to fill and hold its input low.
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  // Longest quiet stretch in a correct run: the hold-off plus one sample,
  // three alpha recomputes and the settle time, taken several times over.
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 25;
  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned PERIOD_MAX      = 1023;

  // Address slot past the three period registers; writes there must be ignored.
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] macd_value;
    logic signed [DATA_W-1:0] signal_value;
    logic signed [DATA_W-1:0] histogram;
    logic                     period_error;
  } macd_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [DATA_W-1:0]  price_i;
  logic                      series_start_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DATA_W-1:0]  macd_value_o;
  logic signed [DATA_W-1:0]  signal_value_o;
  logic signed [DATA_W-1:0]  histogram_o;
  logic                      period_error_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_ADDR_W-1:0]     paddr;
  logic [APB_DATA_W-1:0]     pwdata;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  // Shadow of the block: periods, rounded alphas and the three Q16.32 averages.
  logic [PERIOD_W-1:0]       period_q [3];
  logic [FRACTION_BITS:0]    alpha_q  [3];
  logic signed [AVG_W-1:0]   fast_avg_q;
  logic signed [AVG_W-1:0]   slow_avg_q;
  logic signed [AVG_W-1:0]   signal_avg_q;

  macd_result_t              pending_macd_results [$];
  int unsigned               samples_sent;
  int unsigned               results_seen;
  int unsigned               mismatch_count;
  int unsigned               quiet_cycles;
  int unsigned               hold_off_cycles;
  bit                        gaps_enabled;

  macd_ema_filter_bank #(
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .price_i        (price_i),
    .series_start_i (series_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .macd_value_o   (macd_value_o),
    .signal_value_o (signal_value_o),
    .histogram_o    (histogram_o),
    .period_error_o (period_error_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the averages
  // ---------------------------------------------------------------------------

  // alpha = 2 / (period + 1), rounded half up to FRACTION_BITS, capped at 1.0
  function automatic logic [FRACTION_BITS:0] alpha_for(input logic [PERIOD_W-1:0] period);
    longint unsigned unity, den, a;
    unity = 64'd1 << FRACTION_BITS;
    den   = 64'(period) + 64'd1;
    a     = ((unity << 2) + den) / (den << 1);
    if (a > unity) a = unity;
    return a[FRACTION_BITS:0];
  endfunction

  // Move avg towards target by alpha times the distance, rounding the step half up
  // and never overshooting. Split the magnitude so the product stays in range.
  function automatic longint ema_step(input longint avg, input longint target,
                                     input logic [FRACTION_BITS:0] alpha);
    longint          diff;
    longint unsigned mag, hi, lo, lp, step, a;
    diff = target - avg;
    mag  = (diff < 0) ? -diff : diff;
    a    = 64'(alpha);
    hi   = mag >> FRACTION_BITS;
    lo   = mag & ((64'd1 << FRACTION_BITS) - 64'd1);
    lp   = lo * a + (64'd1 << (FRACTION_BITS - 1));
    step = hi * a + (lp >> FRACTION_BITS);
    if (step > mag) step = mag;
    return (diff < 0) ? avg - longint'(step) : avg + longint'(step);
  endfunction

  // Q16.32 to Q16.16, round half up
  function automatic longint to_q16(input longint v);
    return (v + (longint'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
    if (v > longint'(DATA_MAX)) return DATA_MAX;
    if (v < longint'(DATA_MIN)) return DATA_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Advance the shadow state by one accepted sample and queue the result it gives.
  function automatic void predict_macd(input logic signed [DATA_W-1:0] price,
                                       input logic seed);
    macd_result_t r;
    longint       target;
    r.macd_value   = '0;
    r.signal_value = '0;
    r.histogram    = '0;
    r.period_error = 1'b0;
    if (period_q[REG_FAST] >= period_q[REG_SLOW] || period_q[REG_FAST] == 0 ||
        period_q[REG_SLOW] == 0 || period_q[REG_SIGNAL] == 0) begin
      // bad periods: zeros with the flag, state untouched
      r.period_error = 1'b1;
    end else begin
      target = longint'(price) * (longint'(1) << GUARD_BITS);
      if (seed) begin
        fast_avg_q   = target;
        slow_avg_q   = target;
        signal_avg_q = '0;
        r.macd_value = '0;
      end else begin
        fast_avg_q   = ema_step(fast_avg_q, target, alpha_q[REG_FAST]);
        slow_avg_q   = ema_step(slow_avg_q, target, alpha_q[REG_SLOW]);
        r.macd_value = clamp32(to_q16(longint'(fast_avg_q) - longint'(slow_avg_q)));
        signal_avg_q = ema_step(signal_avg_q,
                                longint'(r.macd_value) * (longint'(1) << GUARD_BITS),
                                alpha_q[REG_SIGNAL]);
      end
      r.signal_value = clamp32(to_q16(longint'(signal_avg_q)));
      r.histogram    = clamp32(longint'(r.macd_value) - longint'(r.signal_value));
    end
    pending_macd_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  // Offer one sample, after a random gap when gaps are enabled, and hold it until the transfer.
  task automatic send_sample(input logic signed [DATA_W-1:0] price, input logic seed);
    int unsigned gap;
    gap = gaps_enabled ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    price_i        <= price;
    series_start_i <= seed;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_macd(price, seed);
    samples_sent++;
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    while (pending_macd_results.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup, access until pready, then back to idle.
  task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a period with junk in the unused upper bits, then read it back.
  task automatic write_period(input logic [REG_IDX_W-1:0] idx,
                              input logic [PERIOD_W-1:0] period);
    logic [APB_DATA_W-1:0] wdata;
    logic [APB_DATA_W-1:0] readback;
    wdata = $urandom;
    wdata[PERIOD_W-1:0] = period;
    apb_access(1'b1, {idx, 2'b00}, wdata, readback);
    period_q[idx] = period;
    alpha_q[idx]  = alpha_for(period);
    apb_access(1'b0, {idx, 2'b00}, '0, readback);
    if (readback !== APB_DATA_W'(period))
      report_mismatch($sformatf("register %0d reads %0d after writing %0d",
                                idx, readback, period));
  endtask

  task automatic set_periods(input logic [PERIOD_W-1:0] fast, input logic [PERIOD_W-1:0] slow,
                             input logic [PERIOD_W-1:0] sig);
    write_period(REG_FAST, fast);
    write_period(REG_SLOW, slow);
    write_period(REG_SIGNAL, sig);
  endtask

  // A price walk of the given length, seeded or carrying on from the current averages.
  task automatic send_series(input int unsigned length, input logic seeded);
    logic signed [DATA_W-1:0] level;
    int                       span;
    level = $urandom;
    if ($urandom_range(0, 1)) level = level >>> 8;
    span = 1 << $urandom_range(4, 24);
    send_sample(level, seeded);
    for (int unsigned i = 1; i < length; i++) begin
      case ($urandom_range(0, 9))
        0: level = $urandom;
        1: level = $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
        default: level = level + ($signed($urandom_range(0, 2 * span)) - span);
      endcase
      send_sample(level, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: sink with random stalls, checker, watchdog
  // ---------------------------------------------------------------------------

  // Stall before each result; a requested hold-off replaces one random stall.
  initial begin : result_sink
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles != 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end else
        stall = gaps_enabled ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_ready_i));
    end
  end

  // Compare every result transfer with the oldest expectation, field by field.
  always @(posedge clk_i) begin : result_check
    macd_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_macd_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: macd %0d signal %0d",
                                  macd_value_o, signal_value_o));
      end else begin
        want = pending_macd_results.pop_front();
        if (macd_value_o !== want.macd_value)
          report_mismatch($sformatf("result %0d macd_value %0d, want %0d",
                                    results_seen, macd_value_o, want.macd_value));
        if (signal_value_o !== want.signal_value)
          report_mismatch($sformatf("result %0d signal_value %0d, want %0d",
                                    results_seen, signal_value_o, want.signal_value));
        if (histogram_o !== want.histogram)
          report_mismatch($sformatf("result %0d histogram %0d, want %0d",
                                    results_seen, histogram_o, want.histogram));
        if (period_error_o !== want.period_error)
          report_mismatch($sformatf("result %0d period_error %b, want %b",
                                    results_seen, period_error_o, want.period_error));
      end
      results_seen++;
    end
  end

  // Count cycles without any transfer on either channel or the register port.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o === 1'b1) ||
        (out_valid_o === 1'b1 && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles", $time, quiet_cycles);
      $display("macd_ema_filter_bank_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No seed since reset: the averages move from zero at the reset periods.
  task automatic test_unseeded_start();
    send_sample(DATA_MAX, 1'b0);
    send_sample(DATA_MIN, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
  endtask

  // Seeding gives zeros and restarts the averages, also twice in a row.
  task automatic test_series_seed();
    send_sample(32'sd1, 1'b1);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(DATA_MIN, 1'b1);
    send_sample(DATA_MAX, 1'b1);
    send_sample(-32'sd65536, 1'b0);
  endtask

  // Extreme periods: full-scale swings drive macd and signal into saturation.
  task automatic test_extreme_periods();
    wait_until_drained();
    set_periods(1, PERIOD_MAX, 1);
    send_sample(DATA_MIN, 1'b1);
    send_sample(DATA_MAX, 1'b0);
    send_sample(DATA_MAX, 1'b0);
    send_sample(DATA_MIN, 1'b0);
    send_sample(DATA_MIN, 1'b0);
    wait_until_drained();
    set_periods(PERIOD_MAX - 1, PERIOD_MAX, PERIOD_MAX);
    send_sample(32'sd0, 1'b1);
    send_sample(DATA_MAX, 1'b0);
    send_sample(DATA_MIN, 1'b0);
    send_sample(32'sd1, 1'b0);
  endtask

  // Bad period settings flag an error and leave the averages alone; a write past
  // the last register must change nothing.
  task automatic test_invalid_periods();
    logic [APB_DATA_W-1:0] unused;
    wait_until_drained();
    set_periods(500, 500, 9);
    send_sample(32'sh0123_4567, 1'b1);
    send_sample(DATA_MIN, 1'b0);
    wait_until_drained();
    write_period(REG_FAST, 600);
    send_sample(DATA_MAX, 1'b0);
    wait_until_drained();
    set_periods(0, SLOW_PERIOD_RST, SIGNAL_PERIOD_RST);
    send_sample(32'sd7, 1'b0);
    wait_until_drained();
    set_periods(FAST_PERIOD_RST, 0, SIGNAL_PERIOD_RST);
    send_sample(32'sd7, 1'b1);
    wait_until_drained();
    set_periods(FAST_PERIOD_RST, SLOW_PERIOD_RST, 0);
    send_sample(-32'sd7, 1'b0);
    wait_until_drained();
    set_periods(FAST_PERIOD_RST, SLOW_PERIOD_RST, SIGNAL_PERIOD_RST);
    apb_access(1'b1, {REG_UNMAPPED, 2'b00}, $urandom, unused);
    send_sample(32'sh0010_0000, 1'b0);
    send_sample(-32'sh0010_0000, 1'b0);
  endtask

  // Hold the result side off for a long stretch while samples keep coming, so
  // the block fills and holds its input low.
  task automatic test_hold_off_backpressure();
    wait_until_drained();
    gaps_enabled    = 1'b0;
    hold_off_cycles = HOLD_OFF_CYCLES;
    send_series(16, 1'b1);
    gaps_enabled    = 1'b1;
  endtask

  // Pause mid-series until everything is out, then carry on without a seed.
  task automatic test_drain_pause();
    send_series(8, 1'b1);
    wait_until_drained();
    send_series(8, 1'b0);
  endtask

  task automatic choose_random_periods();
    logic [PERIOD_W-1:0] fast, slow, sig;
    case ($urandom_range(0, 7))
      0: begin
        // invalid: slow not above fast, possibly zero
        fast = $urandom_range(1, PERIOD_MAX);
        slow = $urandom_range(0, fast);
        sig  = $urandom_range(0, PERIOD_MAX);
      end
      1: begin
        fast = 1;
        slow = PERIOD_MAX;
        sig  = $urandom_range(0, 1) ? 1 : PERIOD_MAX;
      end
      2: begin
        fast = PERIOD_MAX - 1;
        slow = PERIOD_MAX;
        sig  = $urandom_range(1, PERIOD_MAX);
      end
      default: begin
        fast = $urandom_range(1, 40);
        slow = $urandom_range(fast + 1, fast + 60);
        sig  = $urandom_range(1, 30);
      end
    endcase
    set_periods(fast, slow, sig);
  endtask

  // Phases of random periods, each carrying a few series of random walks with
  // occasional jumps, full-scale values and unseeded starts.
  task automatic test_random_traffic();
    int unsigned series_count;
    while (samples_sent < ITEM_TARGET) begin
      wait_until_drained();
      choose_random_periods();
      series_count = $urandom_range(2, 5);
      repeat (series_count) begin
        gaps_enabled = ($urandom_range(0, 3) != 0);
        send_series($urandom_range(1, 25), $urandom_range(0, 7) != 0);
      end
    end
    gaps_enabled = 1'b1;
  endtask

  initial begin : test_sequence
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    price_i        <= '0;
    series_start_i <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    samples_sent    = 0;
    results_seen    = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    hold_off_cycles = 0;
    gaps_enabled    = 1'b1;

    // reset state of the shadow
    period_q[REG_FAST]   = FAST_PERIOD_RST;
    period_q[REG_SLOW]   = SLOW_PERIOD_RST;
    period_q[REG_SIGNAL] = SIGNAL_PERIOD_RST;
    alpha_q[REG_FAST]    = alpha_for(FAST_PERIOD_RST);
    alpha_q[REG_SLOW]    = alpha_for(SLOW_PERIOD_RST);
    alpha_q[REG_SIGNAL]  = alpha_for(SIGNAL_PERIOD_RST);
    fast_avg_q           = '0;
    slow_avg_q           = '0;
    signal_avg_q         = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded_start();
    test_series_seed();
    test_extreme_periods();
    test_invalid_periods();
    test_hold_off_backpressure();
    test_drain_pause();
    test_random_traffic();

    // let any stray result show before the verdict
    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("macd_ema_filter_bank_test: PASS");
    else
      $display("macd_ema_filter_bank_test: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mef_pkg.sv
rtl/mef_alpha_div.sv
rtl/mef_ema_unit.sv
rtl/macd_ema_filter_bank.sv
tb/macd_ema_filter_bank_test.sv
